FILE: src/ssm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, codes and helpers for the sequenced single-slot mailbox.
// ----------------------------------------------------------------------------
package ssm_pkg;

   // Stored tag width (2..32) and the fixed width of tag fields on the ports.
   localparam int SEQ_WIDTH = 32;
   localparam int TAG_WIDTH = 32;
   localparam int MODE_WIDTH = 3;
   localparam int CODE_WIDTH = 2;

   // Event codes.
   localparam logic [MODE_WIDTH-1:0] MODE_RESERVE  = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_ARM      = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_POLL     = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_GIVE_UP  = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_RELEASE  = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_CLAIM    = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_COMPLETE = 3'd6;

   // Slot state codes as reported on the result channel.
   localparam logic [CODE_WIDTH-1:0] SLOT_CODE_IDLE    = 2'd0;
   localparam logic [CODE_WIDTH-1:0] SLOT_CODE_ARMED   = 2'd1;
   localparam logic [CODE_WIDTH-1:0] SLOT_CODE_RUNNING = 2'd2;
   localparam logic [CODE_WIDTH-1:0] SLOT_CODE_DONE    = 2'd3;

   typedef enum logic [3:0] {
      SLOT_IDLE    = 4'b0001,
      SLOT_ARMED   = 4'b0010,
      SLOT_RUNNING = 4'b0100,
      SLOT_DONE    = 4'b1000
   } slot_state_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [TAG_WIDTH-1:0]  ticket_seq;
      logic                  holds_lock;
      logic                  collected;
   } req_item_type;

   typedef struct packed {
      logic                  ok;
      logic [TAG_WIDTH-1:0]  seq_out;
      logic                  execute;
      logic                  signal_done;
      logic [CODE_WIDTH-1:0] slot_state;
      logic [TAG_WIDTH-1:0]  last_done_seq;
      logic                  abandoned_flag;
   } rsp_item_type;

   // Port tag vs stored tag; bits above SEQ_WIDTH never match.
   function automatic logic tag_eq(input logic [TAG_WIDTH-1:0] tk,
                                   input logic [SEQ_WIDTH-1:0] stored);
      return tk == TAG_WIDTH'(stored);
   endfunction

   function automatic logic [CODE_WIDTH-1:0] slot_code(input slot_state_type st);
      logic [CODE_WIDTH-1:0] code;
      unique case (st)
         SLOT_IDLE:    code = SLOT_CODE_IDLE;
         SLOT_ARMED:   code = SLOT_CODE_ARMED;
         SLOT_RUNNING: code = SLOT_CODE_RUNNING;
         SLOT_DONE:    code = SLOT_CODE_DONE;
         default:      code = SLOT_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

FILE: src/ssm_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_req_if
// Event channel: valid/ready plus one event item.
// ----------------------------------------------------------------------------
interface ssm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [31:0] ticket_seq;
   logic        holds_lock;
   logic        collected;

   modport source (output valid, mode, ticket_seq, holds_lock, collected,
                   input ready);
   modport sink   (input valid, mode, ticket_seq, holds_lock, collected,
                   output ready);
endinterface
`default_nettype wire

FILE: src/ssm_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_rsp_if
// Result channel: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface ssm_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [31:0] seq_out;
   logic        execute;
   logic        signal_done;
   logic [1:0]  slot_state;
   logic [31:0] last_done_seq;
   logic        abandoned_flag;

   modport source (output valid, ok, seq_out, execute, signal_done, slot_state,
                   last_done_seq, abandoned_flag,
                   input ready);
   modport sink   (input valid, ok, seq_out, execute, signal_done, slot_state,
                   last_done_seq, abandoned_flag,
                   output ready);
endinterface
`default_nettype wire

FILE: src/ssm_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_csr_if
// Register write channel for channel_enabled.
// ----------------------------------------------------------------------------
interface ssm_csr_if;
   logic valid;
   logic ready;
   logic wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface
`default_nettype wire

FILE: src/sequenced_single_slot_mailbox.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sequenced_single_slot_mailbox
// Single-slot producer/consumer mailbox with sequence tags and abandon mark.
// ----------------------------------------------------------------------------
// Takes one event item per cycle on req_chan (while rsp_chan is not stalled)
// and returns exactly one result item per event on rsp_chan, in order. An
// accepted item lands in an input register, is applied to the slot by one
// short layer of compare/update logic once that register advances, and its
// result is registered in the output register that drives rsp_chan.valid.
// Input and output registers run as a two-stage pipe, so a full rate of one
// item per cycle holds as long as rsp_chan.ready stays high; a stall on the
// result side backs up into req_chan.ready. The event stream sets the order
// of slot updates, one per cycle in the apply stage while it advances.
// csr_chan writes channel_enabled (always ready); write it only with no item
// in flight. While it is 0 every event fails, state is kept, and the result
// reads idle with zero tags.
module sequenced_single_slot_mailbox import ssm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ssm_req_if.sink   req_chan,
   ssm_rsp_if.source rsp_chan,
   ssm_csr_if.sink   csr_chan
);

   logic         enable_ff, enable_in;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         req_fire;
   logic         advance;
   rsp_item_type slot_result;

   // stage advances when the result register is free or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      if (csr_chan.valid) begin
         enable_in = csr_chan.wdata;
      end

      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      in_item_in = in_item_ff;
      if (req_fire) begin
         in_item_in.mode       = req_chan.mode;
         in_item_in.ticket_seq = req_chan.ticket_seq;
         in_item_in.holds_lock = req_chan.holds_lock;
         in_item_in.collected  = req_chan.collected;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      out_item_in = advance ? slot_result : out_item_ff;
   end

   ssm_slot u_slot (
      .clock  (clock),
      .reset  (reset),
      .enable (enable_ff),
      .fire   (advance),
      .item   (in_item_ff),
      .result (slot_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.ok             = out_item_ff.ok;
   assign rsp_chan.seq_out        = out_item_ff.seq_out;
   assign rsp_chan.execute        = out_item_ff.execute;
   assign rsp_chan.signal_done    = out_item_ff.signal_done;
   assign rsp_chan.slot_state     = out_item_ff.slot_state;
   assign rsp_chan.last_done_seq  = out_item_ff.last_done_seq;
   assign rsp_chan.abandoned_flag = out_item_ff.abandoned_flag;

   // disabled channel: applied event yields a failing, idle-looking result
   a_disabled_fails: assert property (@(posedge clock) disable iff (reset)
      (advance && !enable_ff) |=>
         (out_valid_ff && !out_item_ff.ok && out_item_ff.slot_state == SLOT_CODE_IDLE))
      else $error("disabled channel produced a live result");

   // done signal only when the slot ends in done
   a_signal_done_state: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.signal_done) |->
         (out_item_ff.ok && out_item_ff.slot_state == SLOT_CODE_DONE))
      else $error("signal_done without done state");

   // execute only on a successful claim, which leaves the slot running
   a_execute_claim: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.execute) |->
         (out_item_ff.ok && out_item_ff.slot_state == SLOT_CODE_RUNNING
          && out_item_ff.seq_out != '0))
      else $error("execute outside a successful claim");

   // accepting into a full input register needs that stage to move on
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_fire && in_valid_ff) |-> advance)
      else $error("input register overrun");

endmodule
`default_nettype wire

FILE: src/ssm_slot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_slot
// Slot state, tag counter, done tag and abandon mark; applies one event.
// ----------------------------------------------------------------------------
module ssm_slot import ssm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   slot_state_type       state_ff, state_in;
   logic [SEQ_WIDTH-1:0] cur_seq_ff, cur_seq_in;
   logic [SEQ_WIDTH-1:0] done_seq_ff, done_seq_in;
   logic                 abandon_ff, abandon_in;

   logic                 owner;
   logic                 cur_match;
   logic                 done_match;
   logic                 tk_nonzero;
   logic [SEQ_WIDTH-1:0] seq_inc;
   logic                 ok;
   logic [SEQ_WIDTH-1:0] sq;
   logic                 ex;
   logic                 sig;

   assign tk_nonzero = item.ticket_seq != '0;
   assign owner      = item.holds_lock && tk_nonzero;
   assign cur_match  = tag_eq(item.ticket_seq, cur_seq_ff);
   assign done_match = tag_eq(item.ticket_seq, done_seq_ff);

   // tag counter wraps and skips zero
   always_comb begin
      seq_inc = cur_seq_ff + SEQ_WIDTH'(1);
      if (seq_inc == '0) begin
         seq_inc = SEQ_WIDTH'(1);
      end
   end

   always_comb begin
      state_in    = state_ff;
      cur_seq_in  = cur_seq_ff;
      done_seq_in = done_seq_ff;
      abandon_in  = abandon_ff;
      ok          = 1'b0;
      sq          = '0;
      ex          = 1'b0;
      sig         = 1'b0;
      if (enable) begin
         unique case (item.mode)
            MODE_RESERVE: begin
               if (state_ff == SLOT_IDLE) begin
                  cur_seq_in = seq_inc;
                  abandon_in = 1'b0;
                  sq         = seq_inc;
                  ok         = 1'b1;
               end
            end
            MODE_ARM: begin
               if (owner && state_ff == SLOT_IDLE && cur_match) begin
                  state_in = SLOT_ARMED;
                  ok       = 1'b1;
               end
            end
            MODE_POLL: begin
               ok = owner && state_ff == SLOT_DONE && done_match;
            end
            MODE_GIVE_UP: begin
               if (owner) begin
                  if (state_ff == SLOT_DONE && done_match) begin
                     ok = 1'b1;
                  end else if (cur_match) begin
                     abandon_in = 1'b1;
                  end
               end
            end
            MODE_RELEASE: begin
               if (item.holds_lock && item.collected && state_ff == SLOT_DONE
                   && done_match) begin
                  state_in = SLOT_IDLE;
                  ok       = 1'b1;
               end
            end
            MODE_CLAIM: begin
               if (state_ff == SLOT_ARMED) begin
                  state_in = SLOT_RUNNING;
                  sq       = cur_seq_ff;
                  ex       = !abandon_ff;
                  ok       = 1'b1;
               end
            end
            MODE_COMPLETE: begin
               if (tk_nonzero && state_ff == SLOT_RUNNING && cur_match) begin
                  done_seq_in = cur_seq_ff;
                  if (abandon_ff) begin
                     state_in = SLOT_IDLE;
                  end else begin
                     state_in = SLOT_DONE;
                     sig      = 1'b1;
                  end
                  ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.ok             = ok;
      result.seq_out        = TAG_WIDTH'(sq);
      result.execute        = ex;
      result.signal_done    = sig;
      result.slot_state     = enable ? slot_code(state_in) : SLOT_CODE_IDLE;
      result.last_done_seq  = enable ? TAG_WIDTH'(done_seq_in) : '0;
      result.abandoned_flag = enable && abandon_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SLOT_IDLE;
         cur_seq_ff  <= '0;
         done_seq_ff <= '0;
         abandon_ff  <= 1'b0;
      end else if (fire) begin
         state_ff    <= state_in;
         cur_seq_ff  <= cur_seq_in;
         done_seq_ff <= done_seq_in;
         abandon_ff  <= abandon_in;
      end
   end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sequenced single-slot mailbox.
// ----------------------------------------------------------------------------
// Drives event items through req_chan with bursty gaps and stalls rsp_chan on
// a rotating ready pattern. An in-bench model of the slot (state, tag counter,
// done tag, abandon mark, enable) predicts each result item as its event is
// accepted. Results are checked in order, field by field. The run covers the
// disabled channel, a directed producer/consumer lifecycle with the abandon
// path, enable toggled while the slot holds work, and random traffic made mostly of
// well-formed transactions with noise mixed in.
// ----------------------------------------------------------------------------
module tb_top import ssm_pkg::*; ();

   localparam int CLK_HALF    = 2;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 6;      // two-stage pipe plus margin
   localparam int CYCLE_LIMIT  = 400000;

   // Mode 7 has no meaning; the block must fail it.
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 3'd7;

   localparam logic [TAG_WIDTH:0] ONE_WIDE = (TAG_WIDTH+1)'(1);
   localparam logic [TAG_WIDTH:0] TAG_MASK = (ONE_WIDE << SEQ_WIDTH) - ONE_WIDE;

   logic clock;
   logic reset;

   ssm_req_if req_if ();
   ssm_rsp_if rsp_if ();
   ssm_csr_if csr_if ();

   sequenced_single_slot_mailbox i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // ---------------------------------------------------------------------
   // Slot model: its own copy of the register and the stored state
   // ---------------------------------------------------------------------
   logic                  chan_en;
   logic [CODE_WIDTH-1:0] slot_now;
   logic [TAG_WIDTH-1:0]  cur_tag;      // also the tag counter
   logic [TAG_WIDTH-1:0]  done_tag;
   logic                  abandon;

   rsp_item_type mailbox_replies_due[$];

   // bookkeeping
   int n_errors = 0;
   int n_sent = 0;
   int n_results = 0;
   int n_csr = 0;
   int n_signals = 0;
   int n_dropped_claims = 0;
   int n_by_mode[8];
   int cycle_count = 0;

   // sender burst control, receiver stall pattern
   bit          sender_idles = 1'b1;
   int          burst_left = 0;
   bit          rcv_stalls = 1'b1;
   logic [15:0] rdy_pattern = 16'hffff;
   logic [3:0]  rdy_tick = '0;

   rsp_item_type got_reply;
   rsp_item_type want_reply;

   // ---------------------------------------------------------------------
   // Clock, cycle limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run hit the cycle limit with %0d results outstanding",
                  mailbox_replies_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Mailbox model: one event in, one expected result out
   // ---------------------------------------------------------------------
   function automatic rsp_item_type apply_mailbox_event(input req_item_type ev);
      rsp_item_type r;
      logic owner;
      logic [TAG_WIDTH:0] bumped;
      r = '0;
      owner = ev.holds_lock && (ev.ticket_seq != '0);
      if (chan_en) begin
         case (ev.mode)
            MODE_RESERVE: begin
               // lock is not looked at on reserve
               if (slot_now == SLOT_CODE_IDLE) begin
                  bumped = {1'b0, cur_tag} + ONE_WIDE;
                  bumped = bumped & TAG_MASK;
                  cur_tag = bumped[TAG_WIDTH-1:0];
                  if (cur_tag == '0) cur_tag = 1;   // tag 0 means none
                  abandon = 1'b0;
                  r.seq_out = cur_tag;
                  r.ok = 1'b1;
               end
            end
            MODE_ARM: begin
               if (owner && slot_now == SLOT_CODE_IDLE && cur_tag == ev.ticket_seq) begin
                  slot_now = SLOT_CODE_ARMED;
                  r.ok = 1'b1;
               end
            end
            MODE_POLL: begin
               if (owner && slot_now == SLOT_CODE_DONE && done_tag == ev.ticket_seq)
                  r.ok = 1'b1;
            end
            MODE_GIVE_UP: begin
               if (owner) begin
                  if (slot_now == SLOT_CODE_DONE && done_tag == ev.ticket_seq)
                     r.ok = 1'b1;
                  else if (cur_tag == ev.ticket_seq)
                     abandon = 1'b1;
               end
            end
            MODE_RELEASE: begin
               if (ev.holds_lock && ev.collected && slot_now == SLOT_CODE_DONE &&
                   done_tag == ev.ticket_seq) begin
                  slot_now = SLOT_CODE_IDLE;
                  r.ok = 1'b1;
               end
            end
            MODE_CLAIM: begin
               if (slot_now == SLOT_CODE_ARMED) begin
                  slot_now = SLOT_CODE_RUNNING;
                  r.seq_out = cur_tag;
                  r.execute = ~abandon;
                  r.ok = 1'b1;
               end
            end
            MODE_COMPLETE: begin
               if (ev.ticket_seq != '0 && slot_now == SLOT_CODE_RUNNING &&
                   cur_tag == ev.ticket_seq) begin
                  done_tag = ev.ticket_seq;
                  // abandoned work goes straight back to idle, no wake-up
                  if (abandon) begin
                     slot_now = SLOT_CODE_IDLE;
                  end else begin
                     slot_now = SLOT_CODE_DONE;
                     r.signal_done = 1'b1;
                  end
                  r.ok = 1'b1;
               end
            end
            default: ;
         endcase
         r.slot_state = slot_now;
         r.last_done_seq = done_tag;
         r.abandoned_flag = abandon;
      end
      // disabled: result reads idle with zero tags, stored state untouched
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: ready follows a 16-bit pattern, reloaded as the 4-bit tick wraps; the tick counts cycles
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (rdy_tick == 4'd0) begin
         if ($urandom_range(0, 7) == 0)
            rdy_pattern = 16'h8000;                 // one long stall
         else
            rdy_pattern = 16'($urandom()) | 16'h8421; // short stalls only
      end
      rsp_if.ready = rcv_stalls ? rdy_pattern[rdy_tick] : 1'b1;
      rdy_tick = rdy_tick + 4'd1;
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      n_errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_reply.ok             = rsp_if.ok;
         got_reply.seq_out        = rsp_if.seq_out;
         got_reply.execute        = rsp_if.execute;
         got_reply.signal_done    = rsp_if.signal_done;
         got_reply.slot_state     = rsp_if.slot_state;
         got_reply.last_done_seq  = rsp_if.last_done_seq;
         got_reply.abandoned_flag = rsp_if.abandoned_flag;
         if (mailbox_replies_due.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
         end else begin
            want_reply = mailbox_replies_due.pop_front();
            if (got_reply.ok !== want_reply.ok)
               report_mismatch($sformatf("result %0d ok: got %b want %b",
                  n_results, got_reply.ok, want_reply.ok));
            if (got_reply.seq_out !== want_reply.seq_out)
               report_mismatch($sformatf("result %0d seq_out: got %h want %h",
                  n_results, got_reply.seq_out, want_reply.seq_out));
            if (got_reply.execute !== want_reply.execute)
               report_mismatch($sformatf("result %0d execute: got %b want %b",
                  n_results, got_reply.execute, want_reply.execute));
            if (got_reply.signal_done !== want_reply.signal_done)
               report_mismatch($sformatf("result %0d signal_done: got %b want %b",
                  n_results, got_reply.signal_done, want_reply.signal_done));
            if (got_reply.slot_state !== want_reply.slot_state)
               report_mismatch($sformatf("result %0d slot_state: got %0d want %0d",
                  n_results, got_reply.slot_state, want_reply.slot_state));
            if (got_reply.last_done_seq !== want_reply.last_done_seq)
               report_mismatch($sformatf("result %0d last_done_seq: got %h want %h",
                  n_results, got_reply.last_done_seq, want_reply.last_done_seq));
            if (got_reply.abandoned_flag !== want_reply.abandoned_flag)
               report_mismatch($sformatf("result %0d abandoned_flag: got %b want %b",
                  n_results, got_reply.abandoned_flag, want_reply.abandoned_flag));
         end
         n_results++;
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // Sends one event item and returns its predicted result. valid is left
   // high so back-to-back items go out without a bubble; anything that
   // stops sending must go through pause_and_drain.
   task automatic send_event(input logic [MODE_WIDTH-1:0] m,
                             input logic [TAG_WIDTH-1:0] tk,
                             input logic lk, input logic cl,
                             output rsp_item_type want);
      req_item_type ev;
      int gap;
      ev.mode = m;
      ev.ticket_seq = tk;
      ev.holds_lock = lk;
      ev.collected = cl;
      if (sender_idles && burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid      = 1'b1;
      req_if.mode       = ev.mode;
      req_if.ticket_seq = ev.ticket_seq;
      req_if.holds_lock = ev.holds_lock;
      req_if.collected  = ev.collected;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      want = apply_mailbox_event(ev);
      mailbox_replies_due.push_back(want);
      burst_left--;
      n_sent++;
      n_by_mode[ev.mode]++;
      if (want.signal_done) n_signals++;
      if (want.ok && ev.mode == MODE_CLAIM && !want.execute) n_dropped_claims++;
   endtask

   // Stop sending and wait until every expected result has been checked.
   task automatic pause_and_drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (mailbox_replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write, only with the pipe empty.
   task automatic write_enable(input logic v);
      pause_and_drain();
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.wdata = v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      chan_en = v;
      n_csr++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Tag picks that hit the compare paths: none, live, done, stale, extremes.
   function automatic logic [TAG_WIDTH-1:0] pick_ticket();
      logic [TAG_WIDTH-1:0] tk;
      case ($urandom_range(0, 5))
         0:       tk = '0;
         1:       tk = cur_tag;
         2:       tk = done_tag;
         3:       tk = cur_tag + 1;
         4:       tk = '1;
         default: tk = $urandom();
      endcase
      return tk;
   endfunction

   task automatic send_noise();
      rsp_item_type e;
      logic [MODE_WIDTH-1:0] m;
      m = MODE_WIDTH'($urandom_range(0, 7));
      send_event(m, pick_ticket(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), e);
   endtask

   // Walk the slot back to idle with legal events, so a reserve can succeed.
   task automatic settle_slot();
      rsp_item_type e;
      int guard;
      guard = 0;
      while (chan_en && slot_now != SLOT_CODE_IDLE && guard < 8) begin
         case (slot_now)
            SLOT_CODE_ARMED:   send_event(MODE_CLAIM, pick_ticket(), 1'b0, 1'b0, e);
            SLOT_CODE_RUNNING: send_event(MODE_COMPLETE, cur_tag, 1'b0, 1'b0, e);
            default:           send_event(MODE_RELEASE, done_tag, 1'b1, 1'b1, e);
         endcase
         guard++;
      end
   endtask

   // One producer/consumer round trip with random detours.
   task automatic run_transaction();
      rsp_item_type e;
      logic [TAG_WIDTH-1:0] tag;
      settle_slot();
      send_event(MODE_RESERVE, pick_ticket(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), e);
      if (!e.ok) return;
      tag = e.seq_out;
      if ($urandom_range(0, 9) == 0)
         send_event(MODE_ARM, tag, 1'b0, 1'b0, e);            // no lock
      send_event(MODE_ARM, tag, 1'b1, 1'($urandom_range(0, 1)), e);
      if ($urandom_range(0, 99) < 15)
         send_event(MODE_GIVE_UP, tag, 1'b1, 1'b0, e);        // abandon early
      repeat ($urandom_range(0, 2)) send_event(MODE_POLL, tag, 1'b1, 1'b0, e);
      send_event(MODE_CLAIM, pick_ticket(), 1'($urandom_range(0, 1)), 1'b0, e);
      if ($urandom_range(0, 9) == 0)
         send_event(MODE_GIVE_UP, tag, 1'b1, 1'b1, e);        // abandon while running
      if ($urandom_range(0, 9) == 0)
         send_event(MODE_COMPLETE, $urandom_range(0, 1) ? tag + 1 : '0, 1'b0, 1'b0, e);
      send_event(MODE_COMPLETE, tag, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), e);
      if (!e.signal_done) return;
      repeat ($urandom_range(1, 3)) send_event(MODE_POLL, tag, 1'b1, 1'b0, e);
      if ($urandom_range(0, 4) == 0)
         send_event(MODE_GIVE_UP, tag, 1'b1, 1'b0, e);
      if ($urandom_range(0, 6) == 0)
         send_event(MODE_RELEASE, tag, 1'b1, 1'b0, e);        // not yet collected
      send_event(MODE_RELEASE, tag, 1'b1, 1'b1, e);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_disabled_channel();
      rsp_item_type e;
      write_enable(1'b0);
      send_event(MODE_RESERVE, '0, 1'b1, 1'b1, e);
      send_event(MODE_ARM, '1, 1'b1, 1'b0, e);
      send_event(MODE_CLAIM, '0, 1'b0, 1'b0, e);
      send_event(MODE_COMPLETE, '1, 1'b1, 1'b1, e);
      send_event(MODE_RELEASE, 32'h1, 1'b1, 1'b1, e);
      send_event(MODE_UNUSED, '1, 1'b1, 1'b1, e);
   endtask

   task automatic test_directed_lifecycle();
      rsp_item_type e;
      logic [TAG_WIDTH-1:0] t;
      write_enable(1'b1);
      // normal round trip, with the failing variants around each step
      send_event(MODE_RESERVE, '0, 1'b0, 1'b0, e);
      t = e.seq_out;
      send_event(MODE_ARM, t, 1'b0, 1'b0, e);        // no lock
      send_event(MODE_ARM, '0, 1'b1, 1'b0, e);       // ticket none
      send_event(MODE_ARM, t, 1'b1, 1'b0, e);
      send_event(MODE_RESERVE, '1, 1'b1, 1'b1, e);   // slot busy
      send_event(MODE_POLL, t, 1'b1, 1'b0, e);       // not ready yet
      send_event(MODE_CLAIM, '0, 1'b0, 1'b0, e);
      send_event(MODE_CLAIM, t, 1'b1, 1'b1, e);      // nothing armed
      send_event(MODE_COMPLETE, '0, 1'b0, 1'b0, e);
      send_event(MODE_COMPLETE, t + 1, 1'b0, 1'b0, e);
      send_event(MODE_COMPLETE, t, 1'b0, 1'b0, e);
      send_event(MODE_POLL, t, 1'b1, 1'b0, e);
      send_event(MODE_POLL, t, 1'b0, 1'b0, e);
      send_event(MODE_GIVE_UP, t, 1'b1, 1'b0, e);    // already done: ok
      send_event(MODE_RELEASE, t, 1'b1, 1'b0, e);
      send_event(MODE_RELEASE, t, 1'b0, 1'b1, e);
      send_event(MODE_RELEASE, t, 1'b1, 1'b1, e);
      send_event(MODE_UNUSED, '1, 1'b1, 1'b1, e);
      // abandoned round trip
      send_event(MODE_RESERVE, '0, 1'b1, 1'b0, e);
      t = e.seq_out;
      send_event(MODE_ARM, t, 1'b1, 1'b1, e);
      send_event(MODE_GIVE_UP, t + 1, 1'b1, 1'b0, e); // wrong tag, no mark
      send_event(MODE_GIVE_UP, t, 1'b1, 1'b0, e);
      send_event(MODE_CLAIM, '0, 1'b0, 1'b0, e);     // execute low
      send_event(MODE_COMPLETE, t, 1'b1, 1'b1, e);   // straight to idle
      send_event(MODE_RELEASE, t, 1'b1, 1'b1, e);    // nothing to release
      send_event(MODE_ARM, '1, 1'b1, 1'b1, e);
   endtask

   // Enable dropped with the slot armed: state must survive the off period.
   task automatic test_enable_toggle();
      rsp_item_type e;
      logic [TAG_WIDTH-1:0] t;
      settle_slot();
      send_event(MODE_RESERVE, '0, 1'b0, 1'b0, e);
      t = e.seq_out;
      send_event(MODE_ARM, t, 1'b1, 1'b0, e);
      write_enable(1'b0);
      repeat (40) send_noise();
      write_enable(1'b1);
      send_event(MODE_CLAIM, '0, 1'b0, 1'b0, e);
      send_event(MODE_COMPLETE, t, 1'b0, 1'b0, e);
      write_enable(1'b0);
      repeat (10) send_noise();
      write_enable(1'b1);
      send_event(MODE_POLL, t, 1'b1, 1'b0, e);
   endtask

   task automatic test_random_traffic(input int n_items, input bit with_pause);
      int start;
      bit paused;
      start = n_sent;
      paused = 1'b0;
      while (n_sent - start < n_items) begin
         // hold off until the pipe is empty once, midway
         if (with_pause && !paused && n_sent - start >= n_items / 2) begin
            pause_and_drain();
            paused = 1'b1;
         end
         if (chan_en && $urandom_range(0, 99) < 75)
            run_transaction();
         else
            send_noise();
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid      = 1'b0;
      req_if.mode       = MODE_RESERVE;
      req_if.ticket_seq = '0;
      req_if.holds_lock = 1'b0;
      req_if.collected  = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.wdata      = 1'b0;
      chan_en  = 1'b0;
      slot_now = SLOT_CODE_IDLE;
      cur_tag  = '0;
      done_tag = '0;
      abandon  = 1'b0;
      foreach (n_by_mode[i]) n_by_mode[i] = 0;

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_channel();
      test_directed_lifecycle();
      test_random_traffic(400, 1'b1);
      test_enable_toggle();
      // full rate: no sender gaps, receiver never stalls
      sender_idles = 1'b0;
      rcv_stalls = 1'b0;
      test_random_traffic(200, 1'b0);
      sender_idles = 1'b1;
      rcv_stalls = 1'b1;
      test_random_traffic(350, 1'b1);

      pause_and_drain();

      $display("Checked %0d results for %0d events (rsv %0d arm %0d poll %0d giveup %0d rel %0d claim %0d cmpl %0d unused %0d)",
               n_results, n_sent, n_by_mode[MODE_RESERVE], n_by_mode[MODE_ARM],
               n_by_mode[MODE_POLL], n_by_mode[MODE_GIVE_UP], n_by_mode[MODE_RELEASE],
               n_by_mode[MODE_CLAIM], n_by_mode[MODE_COMPLETE], n_by_mode[MODE_UNUSED]);
      $display("Enable writes %0d, done wake-ups %0d, claims of abandoned work %0d, mismatches %0d",
               n_csr, n_signals, n_dropped_claims, n_errors);
      if (n_errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
